### hw/rtl/idba_pkg.sv
// ---------------------------------------------------------------------------
// idba_pkg: shared constants and types for the id bitmap allocator
// Pool size, bitmap word geometry, opcode and status codes.
// ---------------------------------------------------------------------------
package idba_pkg;

  localparam int NUM_IDS  = 256;
  localparam int ID_WORDS = (NUM_IDS + 31) / 32;
  localparam int WORD_W   = $clog2(ID_WORDS);
  // wide enough for an 8-bit request id and for NUM_IDS itself
  localparam int EXT_W    = ($clog2(NUM_IDS + 1) > 9) ? $clog2(NUM_IDS + 1) : 9;
  // compare/subtract steps that reduce a hint byte into the id range
  localparam int PREF_STEPS = (NUM_IDS > 255) ? 0 : 255 / NUM_IDS;
  localparam int TAIL_BITS  = NUM_IDS % 32;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [EXT_W-1:0]  ext_t;

  localparam word_t       LAST_WORD = WORD_W'(ID_WORDS - 1);
  // bits of the last word that stand for real ids
  localparam logic [31:0] LAST_MASK = (TAIL_BITS == 0) ? 32'hffff_ffff :
                                      32'((64'd1 << TAIL_BITS) - 64'd1);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_BAD_FREE  = 2'd2
  } status_e;

  typedef struct packed {
    logic       found;
    logic [4:0] idx;
  } ffs_t;

endpackage

### hw/rtl/idba_ffs.sv
// ---------------------------------------------------------------------------
// idba_ffs: free-bit finder for one bitmap word
// Masks off bits past the pool end and returns the lowest free bit.
// ---------------------------------------------------------------------------
module idba_ffs (
  input  idba_pkg::word_t word_i,
  input  logic [31:0]     used_i,
  output idba_pkg::ffs_t  res_o
);

  logic [31:0] avail;

  always_comb begin
    avail = ~used_i & ((word_i == idba_pkg::LAST_WORD) ? idba_pkg::LAST_MASK :
                                                         32'hffff_ffff);
    res_o.found = |avail;
    res_o.idx   = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (avail[i]) begin
        res_o.idx = 5'(i);
      end
    end
  end

endmodule

### hw/rtl/id_bitmap_allocator.sv
// ---------------------------------------------------------------------------
// id_bitmap_allocator: bitmap id pool with next-fit scan hint
// Flow: an accepted request reads the word of the preferred id (or the freed
//   id) and decides in S_LOOKUP from that one word read; if the preferred id
//   is taken, S_SCAN visits up to ID_WORDS words. One item at a time, limited
//   by the single read port of the bitmap memory; the receiver cannot stall.
// Reset: a clearing pass writes every bitmap word, busy high.
// ---------------------------------------------------------------------------
module id_bitmap_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       op_i,
  input  logic [7:0] hint_byte_i,
  input  logic [7:0] release_id_i,
  output logic       done_o,
  output logic [7:0] granted_id_o,
  output logic [1:0] status_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_SCAN
  } state_e;

  state_e               state_q;
  idba_pkg::op_e        op_q;
  logic [4:0]           bit_q;
  idba_pkg::word_t      word_q, start_word_q, cnt_q, clr_q;
  logic                 bad_q;
  logic                 done_q;
  logic [7:0]           granted_q;
  idba_pkg::status_e    status_q;

  // bitmap memory, registered read
  logic [31:0]          mem [idba_pkg::ID_WORDS];
  logic [31:0]          rdata_q;
  logic                 mem_re, mem_we;
  idba_pkg::word_t      mem_raddr, mem_waddr;
  logic [31:0]          mem_wdata;

  idba_pkg::ext_t       pref, rel;
  idba_pkg::word_t      req_word, next_word;
  logic [4:0]           req_bit;
  logic                 req_bad;
  logic [31:0]          bit_mask;
  idba_pkg::ffs_t       ffs;

  idba_ffs u_ffs (
    .word_i (word_q),
    .used_i (rdata_q),
    .res_o  (ffs)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // request decode: reduce hint into range, split ids into word and bit
  always_comb begin
    pref = idba_pkg::EXT_W'(hint_byte_i);
    for (int i = 0; i < idba_pkg::PREF_STEPS; i++) begin
      if (pref >= idba_pkg::EXT_W'(idba_pkg::NUM_IDS)) begin
        pref = pref - idba_pkg::EXT_W'(idba_pkg::NUM_IDS);
      end
    end
    rel     = idba_pkg::EXT_W'(release_id_i);
    req_bad = (rel == '0) || (rel >= idba_pkg::EXT_W'(idba_pkg::NUM_IDS));
    if (idba_pkg::op_e'(op_i) == idba_pkg::OP_ALLOC) begin
      req_word = idba_pkg::WORD_W'(pref >> 5);
      req_bit  = pref[4:0];
    end else begin
      req_word = idba_pkg::WORD_W'(rel >> 5);
      req_bit  = rel[4:0];
    end
  end

  assign next_word = (word_q == idba_pkg::LAST_WORD) ? '0 :
                     word_q + idba_pkg::WORD_W'(1);
  assign bit_mask  = 32'd1 << bit_q;

  // memory port control; writes only in the state that ends a transaction or in
  // the clearing pass, and accepts come from S_IDLE after, so no read races a write
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = req_word;
    mem_we    = 1'b0;
    mem_waddr = word_q;
    mem_wdata = rdata_q | bit_mask;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = (clr_q == '0) ? 32'd1 : 32'd0;
      end
      S_IDLE: begin
        mem_re = start;
      end
      S_LOOKUP: begin
        if (op_q == idba_pkg::OP_ALLOC) begin
          if (!rdata_q[bit_q]) begin
            mem_we = 1'b1;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = start_word_q;
          end
        end else if (!bad_q && rdata_q[bit_q]) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q & ~bit_mask;
        end
      end
      S_SCAN: begin
        if (ffs.found) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q | (32'd1 << ffs.idx);
        end else if (cnt_q != idba_pkg::LAST_WORD) begin
          mem_re    = 1'b1;
          mem_raddr = next_word;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      start_word_q <= '0;
      done_q       <= 1'b0;
      op_q         <= idba_pkg::OP_ALLOC;
      bit_q        <= '0;
      word_q       <= '0;
      cnt_q        <= '0;
      bad_q        <= 1'b0;
      granted_q    <= '0;
      status_q     <= idba_pkg::ST_OK;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + idba_pkg::WORD_W'(1);
          if (clr_q == idba_pkg::LAST_WORD) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q    <= idba_pkg::op_e'(op_i);
            word_q  <= req_word;
            bit_q   <= req_bit;
            bad_q   <= req_bad;
            state_q <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (op_q == idba_pkg::OP_ALLOC) begin
            if (!rdata_q[bit_q]) begin
              done_q    <= 1'b1;
              granted_q <= 8'(idba_pkg::EXT_W'({word_q, bit_q}));
              status_q  <= idba_pkg::ST_OK;
              state_q   <= S_IDLE;
            end else begin
              word_q  <= start_word_q;
              cnt_q   <= '0;
              state_q <= S_SCAN;
            end
          end else begin
            done_q    <= 1'b1;
            granted_q <= '0;
            status_q  <= (!bad_q && rdata_q[bit_q]) ? idba_pkg::ST_OK :
                                                      idba_pkg::ST_BAD_FREE;
            state_q   <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (ffs.found) begin
            done_q       <= 1'b1;
            granted_q    <= 8'(idba_pkg::EXT_W'({word_q, ffs.idx}));
            status_q     <= idba_pkg::ST_OK;
            start_word_q <= word_q;
            state_q      <= S_IDLE;
          end else if (cnt_q == idba_pkg::LAST_WORD) begin
            done_q    <= 1'b1;
            granted_q <= '0;
            status_q  <= idba_pkg::ST_NONE_FREE;
            state_q   <= S_IDLE;
          end else begin
            word_q <= next_word;
            cnt_q  <= cnt_q + idba_pkg::WORD_W'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign granted_id_o = granted_q;
  assign status_o     = status_q;

endmodule

### hw/rtl/idba_chk.sv
// ---------------------------------------------------------------------------
// idba_chk: port-level checker for the id bitmap allocator
// Watches the command handshake and the result strobe over time.
// ---------------------------------------------------------------------------
module idba_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [7:0] granted_id_o,
  input logic [1:0] status_o
);

  // an accepted transaction holds the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result ends its transaction: the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // every result follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  // results with an error status carry no id
  a_no_id_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != idba_pkg::ST_OK) |-> (granted_id_o == 8'd0))
    else $error("nonzero id with error status");

endmodule

bind id_bitmap_allocator idba_chk u_idba_chk (.*);
